// File: rtl/traffic_rate_meter_assert.svh
// Assertion macros for the checker file
`ifndef TRAFFIC_RATE_METER_ASSERT_SVH
`define TRAFFIC_RATE_METER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define TRM_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define TRM_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/trm_pkg.sv
package trm_pkg;
	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	localparam int WIN_W = 7;
	localparam logic [31:0] IMPLAUSIBLE_DELTA = 32'hC000_0000;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [1:0] REG_AVG_WIN = 2'd0;
	localparam logic [1:0] REG_PEAK_WIN = 2'd1;
	localparam logic [1:0] REG_PEAK_KIND = 2'd2;
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// start/status between sequencer and divider
	typedef struct packed {
		logic start;
		logic [63:0] bytes;
		logic [31:0] ms;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] rate;
	} div_rsp_t;
endpackage

// File: rtl/traffic_rate_meter.sv
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
// in      | in        | in_valid/ready     | action, recv_octets, sent_octets, time_ms
// out     | out       | out_valid/ready    | rates, averages, peaks
// One item at a time: a sample makes four passes through the shared rate divider,
// reads the history in two window searches (up to 64 reads each) and in the peak
// scan (up to 64 reads), all before out_valid.
// Reset empties the history at once (fill count).
// in_ready is low while an item is in work or its result waits in the output register.
module traffic_rate_meter import trm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] recv_octets,
	input  logic [31:0] sent_octets,
	input  logic [31:0] time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] recv_rate,
	output logic [31:0] sent_rate,
	output logic [31:0] recv_average,
	output logic [31:0] sent_average,
	output logic [31:0] recv_peak,
	output logic [31:0] sent_peak
);
	logic [WIN_W-1:0] avg_win_q, peak_win_q;
	logic peak_kind_q, busy_q, act_q, done;
	logic [31:0] res [6];
	logic [31:0] r_q, s_q, t_q;
	div_req_t dreq;
	div_rsp_t drsp;

	assign cfg_ready = 1'b1;
	assign in_ready = !busy_q && !out_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_win_q <= WIN_W'(8);
			peak_win_q <= WIN_W'(64);
			peak_kind_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AVG_WIN: avg_win_q <= cfg_data;
				REG_PEAK_WIN: peak_win_q <= cfg_data;
				REG_PEAK_KIND: peak_kind_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input capture and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) busy_q <= 1'b1;
			if (done) begin
				busy_q <= 1'b0;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action;
			r_q <= recv_octets;
			s_q <= sent_octets;
			t_q <= time_ms;
		end
		if (done) begin
			recv_rate <= act_q ? 32'd0 : res[0];
			sent_rate <= act_q ? 32'd0 : res[1];
			recv_average <= act_q ? 32'd0 : res[2];
			sent_average <= act_q ? 32'd0 : res[3];
			recv_peak <= act_q ? 32'd1 : res[4];
			sent_peak <= act_q ? 32'd1 : res[5];
		end
	end

	logic go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_q <= 1'b0;
		else go_q <= in_valid && in_ready;
	end

	trm_seq u_seq (
		.clk, .arst_n, .start(go_q), .action(act_q), .recv_octets(r_q),
		.sent_octets(s_q), .time_ms(t_q), .avg_win(avg_win_q), .peak_win(peak_win_q),
		.peak_kind(peak_kind_q), .done, .res, .dreq, .drsp
	);

	trm_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));
endmodule

// File: rtl/trm_ram.sv
module trm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/trm_div.sv
// Serial rate unit: round(bytes*1000/ms) half up, saturated, 0 when ms is 0.
// Computes floor((2000*bytes + ms) / (2*ms)) by restoring division, one bit a cycle.
module trm_div import trm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int NW = 76;

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [33:0]   den_q;
	logic [34:0]   rem_q;
	logic [6:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          zero_q;
	logic [34:0]   trial;
	logic [35:0]   diff;
	logic [NW-1:0] quo_nx;
	logic [NW-1:0] num_x;

	// 2000*bytes = bytes*2048 - bytes*32 - bytes*16
	assign num_x = ({12'd0, req.bytes} << 11) - ({12'd0, req.bytes} << 5)
		- ({12'd0, req.bytes} << 4) + {44'd0, req.ms};
	assign trial = {rem_q[33:0], num_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};
	assign quo_nx = {quo_q[NW-2:0], ~diff[35]};

	// shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= (req.ms != '0);
				done_q <= (req.ms == '0);
				cnt_q <= 7'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num_x;
			den_q <= {1'b0, req.ms, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
			zero_q <= (req.ms == '0);
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= diff[35] ? trial : diff[34:0];
			quo_q <= quo_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rate = zero_q ? '0 : ((|quo_q[NW-1:32]) ? SAT32 : quo_q[31:0]);
endmodule

// File: rtl/trm_seq.sv
// Sequencer: history in a circular buffer, serial scans and rate unit.
module trm_seq import trm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             action,
	input  logic [31:0]      recv_octets,
	input  logic [31:0]      sent_octets,
	input  logic [31:0]      time_ms,
	input  logic [WIN_W-1:0] avg_win,
	input  logic [WIN_W-1:0] peak_win,
	input  logic             peak_kind,
	output logic             done,
	output logic [31:0]      res [6],
	output div_req_t         dreq,
	input  div_rsp_t         drsp
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RATE = 4'd1, S_RWAIT = 4'd2, S_FIND = 4'd3,
		S_FWAIT = 4'd4, S_AVG = 4'd5, S_AWAIT = 4'd6, S_WRITE = 4'd7, S_PEAK = 4'd8,
		S_PWAIT = 4'd9, S_DONE = 4'd10;
	localparam int CW = HIST_AW + 1;
	localparam int EW = 32 + 64 + 64 + 128;

	logic [3:0] state_q;
	logic [HIST_AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [31:0] prev_r_q, prev_s_q, prev_t_q, dr_q, ds_q, el_q, t_q;
	logic [63:0] tot_r_q, tot_s_q;
	logic dir_q;
	logic [CW-1:0] idx_q;
	logic [31:0] rate_q [2];
	logic [31:0] avg_q [2];
	logic [31:0] peak_q [2];
	logic [HIST_AW-1:0] raddr, waddr;
	logic [EW-1:0] rdata, wdata;
	logic we;
	logic [31:0] dr_c, ds_c;
	logic bad;
	logic [WIN_W-1:0] st_c;
	logic [63:0] my_tot, ent_tot;
	logic [31:0] ent_time, pk_r, pk_s;
	logic [CW-1:0] pn;

	// history entry: time, recv total, sent total, recv rate, sent rate,
	// recv average, sent average
	trm_ram #(.WIDTH(EW), .DEPTH(HIST_DEPTH)) u_hist (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign ent_time = rdata[EW-1 -: 32];
	assign ent_tot = dir_q ? rdata[191:128] : rdata[255:192];
	assign pk_r = peak_kind ? rdata[63:32] : rdata[127:96];
	assign pk_s = peak_kind ? rdata[31:0] : rdata[95:64];
	assign my_tot = dir_q ? tot_s_q : tot_r_q;
	assign dr_c = recv_octets - prev_r_q;
	assign ds_c = sent_octets - prev_s_q;
	assign bad = (recv_octets == '0 && sent_octets == '0) || (prev_r_q == '0 && prev_s_q == '0)
		|| dr_c > IMPLAUSIBLE_DELTA || ds_c > IMPLAUSIBLE_DELTA;
	assign st_c = (avg_win > WIN_W'(HIST_DEPTH - 1)) ? WIN_W'(HIST_DEPTH - 1) : avg_win;
	assign pn = (peak_win > WIN_W'(HIST_DEPTH)) ? CW'(HIST_DEPTH) : CW'(peak_win);

	// entry idx (0 newest) maps behind head; scans skip entries past fill
	assign raddr = head_q - idx_q[HIST_AW-1:0];
	assign waddr = head_q;
	assign we = (state_q == S_WRITE);
	assign wdata = {t_q, tot_r_q, tot_s_q, rate_q[0], rate_q[1], avg_q[0], avg_q[1]};

	always_comb begin
		dreq = '0;
		if (state_q == S_RATE) begin
			dreq.start = 1'b1;
			dreq.bytes = {32'd0, dir_q ? ds_q : dr_q};
			dreq.ms = el_q;
		end else if (state_q == S_AVG) begin
			// window start at the new entry itself gives zero bytes over zero time
			dreq.start = 1'b1;
			dreq.bytes = (idx_q == '0) ? '0 : my_tot - ent_tot;
			dreq.ms = (idx_q == '0) ? '0 : t_q - ent_time;
		end
	end

	assign done = (state_q == S_DONE);
	assign res[0] = rate_q[0];
	assign res[1] = rate_q[1];
	assign res[2] = avg_q[0];
	assign res[3] = avg_q[1];
	assign res[4] = peak_q[0];
	assign res[5] = peak_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			fill_q <= '0;
			prev_r_q <= '0;
			prev_s_q <= '0;
			prev_t_q <= '0;
			tot_r_q <= '0;
			tot_s_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					if (action == ACT_CLEAR) begin
						fill_q <= '0;
						tot_r_q <= '0;
						tot_s_q <= '0;
						prev_r_q <= '0;
						prev_s_q <= '0;
						state_q <= S_DONE;
					end else begin
						dr_q <= bad ? '0 : dr_c;
						ds_q <= bad ? '0 : ds_c;
						tot_r_q <= tot_r_q + {32'd0, bad ? 32'd0 : dr_c};
						tot_s_q <= tot_s_q + {32'd0, bad ? 32'd0 : ds_c};
						prev_r_q <= recv_octets;
						prev_s_q <= sent_octets;
						el_q <= time_ms - prev_t_q;
						prev_t_q <= time_ms;
						t_q <= time_ms;
						head_q <= head_q + 1'b1;
						dir_q <= 1'b0;
						state_q <= S_RATE;
					end
				end
				S_RATE: state_q <= S_RWAIT;
				S_RWAIT: if (drsp.done) begin
					rate_q[dir_q] <= drsp.rate;
					dir_q <= ~dir_q;
					if (dir_q) begin
						// find start of average window; new entry not yet stored
						idx_q <= CW'(st_c);
						state_q <= S_FIND;
					end else begin
						state_q <= S_RATE;
					end
				end
				S_FIND: state_q <= S_FWAIT;
				S_FWAIT: begin
					// entry idx holds total idx back; index 0 is the new total itself
					if (idx_q == '0) begin
						state_q <= S_AVG;
					end else if (idx_q <= fill_q && ent_tot == '0) begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_FIND;
					end else if (idx_q > fill_q) begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_FIND;
					end else begin
						state_q <= S_AVG;
					end
				end
				S_AVG: state_q <= S_AWAIT;
				S_AWAIT: if (drsp.done) begin
					avg_q[dir_q] <= drsp.rate;
					dir_q <= ~dir_q;
					if (dir_q) begin
						state_q <= S_WRITE;
					end else begin
						idx_q <= CW'(st_c);
						state_q <= S_FIND;
					end
				end
				S_WRITE: begin
					if (fill_q != CW'(HIST_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					peak_q[0] <= 32'd1;
					peak_q[1] <= 32'd1;
					idx_q <= '0;
					state_q <= (pn == '0) ? S_DONE : S_PEAK;
				end
				S_PEAK: state_q <= S_PWAIT;
				S_PWAIT: begin
					if (idx_q < fill_q) begin
						if (pk_r > peak_q[0]) peak_q[0] <= pk_r;
						if (pk_s > peak_q[1]) peak_q[1] <= pk_s;
					end
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == pn) ? S_DONE : S_PEAK;
				end
				S_DONE: begin
					if (action == ACT_CLEAR) begin
						rate_q[0] <= '0;
						rate_q[1] <= '0;
						avg_q[0] <= '0;
						avg_q[1] <= '0;
						peak_q[0] <= 32'd1;
						peak_q[1] <= 32'd1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/trm_checker.sv
`include "traffic_rate_meter_assert.svh"
module trm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] recv_peak,
	input logic [31:0] sent_peak
);
	`TRM_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	`TRM_ASSERT_IMP(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)
	`TRM_ASSERT_IMP(a_peak_floor, clk, arst_n, out_valid, recv_peak != 32'd0 && sent_peak != 32'd0)
	`TRM_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind traffic_rate_meter trm_checker u_trm_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .recv_peak, .sent_peak
);

// File: tb/traffic_rate_meter_test.sv
`timescale 1ns / 100ps

module traffic_rate_meter_test;
	import trm_pkg::*;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        act;
		logic [31:0] rx;
		logic [31:0] tx;
		logic [31:0] ms;
	} sample_t;

	typedef struct packed {
		logic [31:0] rx_rate;
		logic [31:0] tx_rate;
		logic [31:0] rx_avg;
		logic [31:0] tx_avg;
		logic [31:0] rx_peak;
		logic [31:0] tx_peak;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [31:0] recv_octets;
	logic [31:0] sent_octets;
	logic [31:0] time_ms;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] recv_rate;
	logic [31:0] sent_rate;
	logic [31:0] recv_average;
	logic [31:0] sent_average;
	logic [31:0] recv_peak;
	logic [31:0] sent_peak;

	traffic_rate_meter dut (.*);

	// stimulus and expectation stores
	sample_t  pending_samples[$];
	reading_t expected_readings[$];
	int       error_count;
	int       samples_sent;
	int       readings_seen;
	int       idle_cycles;
	int       in_gap;
	int       out_gap;
	bit       in_flight_cfg;

	// meter model state
	logic [6:0]  m_avg_win;
	logic [6:0]  m_peak_win;
	logic        m_peak_kind;
	logic [31:0] m_prev_rx, m_prev_tx, m_prev_ms;
	logic [63:0] m_rx_total, m_tx_total;
	logic [31:0] h_ms[DEPTH];
	logic [63:0] h_rx_tot[DEPTH], h_tx_tot[DEPTH];
	logic [31:0] h_rx_rate[DEPTH], h_tx_rate[DEPTH];
	logic [31:0] h_rx_avg[DEPTH], h_tx_avg[DEPTH];

	// bytes*1000/ms rounded half up, saturated
	function automatic logic [31:0] bytes_per_sec(logic [63:0] bytes, logic [31:0] ms);
		logic [63:0] q, r, frac, v;
		if (ms == 0)
			return 32'd0;
		q = bytes / ms;
		r = bytes % ms;
		if (q > 64'hFFFF_FFFF)
			return SAT32;
		frac = (r * 64'd2000 + ms) / (64'd2 * ms);
		v = q * 64'd1000 + frac;
		return (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
	endfunction

	function automatic logic [31:0] window_rate(ref logic [63:0] tot[DEPTH]);
		int s;
		s = (m_avg_win > DEPTH - 1) ? DEPTH - 1 : m_avg_win;
		while (s > 0 && tot[s] == 0)
			s--;
		return bytes_per_sec(tot[0] - tot[s], h_ms[0] - h_ms[s]);
	endfunction

	function automatic logic [31:0] peak_of(ref logic [31:0] rates[DEPTH],
			ref logic [31:0] avgs[DEPTH]);
		logic [31:0] best;
		int n;
		best = 1;
		n = (m_peak_win > DEPTH) ? DEPTH : m_peak_win;
		for (int i = 0; i < n; i++) begin
			if (m_peak_kind && avgs[i] > best)
				best = avgs[i];
			if (!m_peak_kind && rates[i] > best)
				best = rates[i];
		end
		return best;
	endfunction

	function automatic void clear_meter();
		for (int i = 0; i < DEPTH; i++) begin
			h_ms[i] = 0; h_rx_tot[i] = 0; h_tx_tot[i] = 0;
			h_rx_rate[i] = 0; h_tx_rate[i] = 0; h_rx_avg[i] = 0; h_tx_avg[i] = 0;
		end
		m_rx_total = 0; m_tx_total = 0; m_prev_rx = 0; m_prev_tx = 0;
	endfunction

	function automatic reading_t measure(sample_t s);
		reading_t o;
		logic [31:0] drx, dtx, el;
		if (s.act == ACT_CLEAR) begin
			clear_meter();
			o = '0;
			o.rx_peak = 1;
			o.tx_peak = 1;
			return o;
		end
		drx = s.rx - m_prev_rx;
		dtx = s.tx - m_prev_tx;
		if ((s.rx == 0 && s.tx == 0) || (m_prev_rx == 0 && m_prev_tx == 0) ||
				drx > IMPLAUSIBLE_DELTA || dtx > IMPLAUSIBLE_DELTA) begin
			drx = 0;
			dtx = 0;
		end
		m_prev_rx = s.rx;
		m_prev_tx = s.tx;
		m_rx_total += drx;
		m_tx_total += dtx;
		el = s.ms - m_prev_ms;
		m_prev_ms = s.ms;
		for (int i = DEPTH - 1; i > 0; i--) begin
			h_ms[i] = h_ms[i-1]; h_rx_tot[i] = h_rx_tot[i-1]; h_tx_tot[i] = h_tx_tot[i-1];
			h_rx_rate[i] = h_rx_rate[i-1]; h_tx_rate[i] = h_tx_rate[i-1];
			h_rx_avg[i] = h_rx_avg[i-1]; h_tx_avg[i] = h_tx_avg[i-1];
		end
		h_ms[0] = s.ms;
		h_rx_tot[0] = m_rx_total;
		h_tx_tot[0] = m_tx_total;
		h_rx_rate[0] = bytes_per_sec({32'd0, drx}, el);
		h_tx_rate[0] = bytes_per_sec({32'd0, dtx}, el);
		h_rx_avg[0] = window_rate(h_rx_tot);
		h_tx_avg[0] = window_rate(h_tx_tot);
		o.rx_rate = h_rx_rate[0];
		o.tx_rate = h_tx_rate[0];
		o.rx_avg = h_rx_avg[0];
		o.tx_avg = h_tx_avg[0];
		o.rx_peak = peak_of(h_rx_rate, h_rx_avg);
		o.tx_peak = peak_of(h_tx_rate, h_tx_avg);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch reading %0d %s: got %0h want %0h", readings_seen, what, got, want);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 300);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// input driver: one transfer at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap <= 0;
		end else if (in_valid && !in_ready) begin
		end else if (in_valid && in_ready && pending_samples.size() == 0) begin
			in_valid <= 0;
		end else if (!in_valid && in_gap > 0) begin
			in_gap <= in_gap - 1;
		end else if (pending_samples.size() > 0 && (!in_valid || in_gap == 0)) begin
			sample_t s;
			s = pending_samples.pop_front();
			expected_readings.push_back(measure(s));
			in_valid <= 1;
			action <= s.act;
			recv_octets <= s.rx;
			sent_octets <= s.tx;
			time_ms <= s.ms;
			samples_sent++;
			in_gap <= pick_gap();
		end else if (in_valid && in_ready) begin
			in_valid <= 0;
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				reading_t w;
				readings_seen++;
				if (expected_readings.size() == 0) begin
					$display("unexpected reading %0d", readings_seen);
					error_count++;
				end else begin
					w = expected_readings.pop_front();
					if (recv_rate !== w.rx_rate) report_mismatch("recv_rate", recv_rate, w.rx_rate);
					if (sent_rate !== w.tx_rate) report_mismatch("sent_rate", sent_rate, w.tx_rate);
					if (recv_average !== w.rx_avg)
						report_mismatch("recv_average", recv_average, w.rx_avg);
					if (sent_average !== w.tx_avg)
						report_mismatch("sent_average", sent_average, w.tx_avg);
					if (recv_peak !== w.rx_peak) report_mismatch("recv_peak", recv_peak, w.rx_peak);
					if (sent_peak !== w.tx_peak) report_mismatch("sent_peak", sent_peak, w.tx_peak);
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if ($urandom_range(0, 9) == 0)
					out_gap <= pick_gap();
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_AVG_WIN) m_avg_win = val;
		else if (idx == REG_PEAK_WIN) m_peak_win = val;
		else if (idx == REG_PEAK_KIND) m_peak_kind = val[0];
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || expected_readings.size() > 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_sample(logic a, logic [31:0] r, logic [31:0] s, logic [31:0] t);
		sample_t x;
		x.act = a; x.rx = r; x.tx = s; x.ms = t;
		pending_samples.push_back(x);
	endtask

	// mostly plausible counter streams with random rates and steps
	task automatic add_stream(int n);
		logic [31:0] r, s, t;
		int k;
		r = $urandom; s = $urandom; t = $urandom;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 3)
				add_sample(ACT_CLEAR, $urandom, $urandom, $urandom);
			else if (k < 8)
				add_sample(ACT_SAMPLE, $urandom, $urandom, $urandom);
			else begin
				case ($urandom_range(0, 3))
					0: r += $urandom_range(0, 255);
					1: r += $urandom_range(0, 100000);
					2: r += $urandom;
					default: r += 32'hC000_0000 + $urandom_range(0, 2) - 1;
				endcase
				case ($urandom_range(0, 3))
					0: s += $urandom_range(0, 255);
					1: s += $urandom_range(0, 100000);
					2: s += $urandom;
					default: s += $urandom_range(0, 1) ? 32'hC000_0000 : 32'd0;
				endcase
				case ($urandom_range(0, 3))
					0: t += $urandom_range(0, 3);
					1: t += $urandom_range(1, 2000);
					default: t += $urandom;
				endcase
				add_sample(ACT_SAMPLE, r, s, t);
			end
		end
	endtask

	initial begin
		logic [6:0] aw[6];
		logic [6:0] pw[6];
		error_count = 0; samples_sent = 0; readings_seen = 0; idle_cycles = 0;
		cfg_valid = 0; cfg_index = REG_AVG_WIN; cfg_data = 0;
		action = ACT_SAMPLE; recv_octets = 0; sent_octets = 0; time_ms = 0;
		m_avg_win = 8; m_peak_win = 64; m_peak_kind = 0; m_prev_ms = 0;
		clear_meter();
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: invalid deltas, wraps, zero elapsed, clear, saturation
		add_sample(ACT_SAMPLE, 0, 0, 0);
		add_sample(ACT_SAMPLE, 100, 200, 1000);
		add_sample(ACT_SAMPLE, 1100, 1200, 2000);
		add_sample(ACT_SAMPLE, 1600, 1300, 2000);
		add_sample(ACT_SAMPLE, 0, 0, 3000);
		add_sample(ACT_SAMPLE, 5, 7, 3003);
		add_sample(ACT_SAMPLE, 32'hFFFF_FFF0, 32'hC000_0004, 3004);
		add_sample(ACT_SAMPLE, 32'h0000_0010, 32'hC000_0005, 3005);
		add_sample(ACT_SAMPLE, 32'hC000_0010, 32'h8000_0005, 32'hFFFF_FFFF);
		add_sample(ACT_SAMPLE, 32'hC000_0011, 32'h8000_0006, 32'h0000_0001);
		add_sample(ACT_SAMPLE, 32'h8000_0011, 32'h4000_0006, 32'h0000_0002);
		add_sample(ACT_SAMPLE, 32'h4000_0012, 32'h0000_0007, 32'h0000_0003);
		add_sample(ACT_SAMPLE, 32'h4000_0013, 32'h0000_0009, 32'h0000_0004);
		add_sample(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_sample(ACT_SAMPLE, 1, 1, 32'h0000_0005);
		add_sample(ACT_SAMPLE, 2, 32'hFFFF_FFFF, 32'h0000_0007);
		add_sample(ACT_SAMPLE, 3, 32'h7FFF_FFFF, 32'h8000_0007);
		wait_drained();

		// random phases across window settings, extremes included
		aw = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd63, 7'd8};
		pw = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd5};
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_AVG_WIN, (p < 6) ? aw[p] : $urandom_range(0, 127));
			write_reg(REG_PEAK_WIN, (p < 6) ? pw[p] : $urandom_range(0, 127));
			write_reg(REG_PEAK_KIND, p[0]);
			add_stream(200);
			wait_drained();
		end

		$display("run covered %0d samples and %0d readings over 8 window settings",
			samples_sent, readings_seen);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/trm_pkg.sv
rtl/trm_ram.sv
rtl/trm_div.sv
rtl/trm_seq.sv
rtl/traffic_rate_meter.sv
rtl/trm_checker.sv
tb/traffic_rate_meter_test.sv
